// ----- design/fcmr_pkg.sv -----
// Shared types, constants and helper functions of the feature connector block.
package fcmr_pkg;

  localparam int FCMR_MAX_IN_DIM    = 128;
  localparam int FCMR_MAX_MODEL_DIM = 256;

  localparam int OP_W      = 3;
  localparam int INDEX_W   = 16;
  localparam int VALUE_W   = 32;
  localparam int OUT_IDX_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 40;

  localparam logic [OP_W-1:0] OP_FC1_W   = 3'd0;
  localparam logic [OP_W-1:0] OP_FC1_B   = 3'd1;
  localparam logic [OP_W-1:0] OP_GAIN    = 3'd2;
  localparam logic [OP_W-1:0] OP_FC2_W   = 3'd3;
  localparam logic [OP_W-1:0] OP_FC2_B   = 3'd4;
  localparam logic [OP_W-1:0] OP_FRAME   = 3'd5;
  localparam logic [OP_W-1:0] OP_RD_OUT  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_DIM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_DIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_B1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_B2    = 3'd4;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [63:0] EPS_Q32 = 64'd4295;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  typedef enum logic [0:0] {
    DSU_DIV,
    DSU_SQRT
  } dsu_op_e;

  typedef struct packed {
    logic        start;
    dsu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } dsu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } dsu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_F1_BIAS,
    ST_F1_INIT,
    ST_F1_RD,
    ST_F1_MUL,
    ST_F1_ACC,
    ST_F1_HID,
    ST_F1_SQM,
    ST_F1_SQA,
    ST_MEAN_GO,
    ST_MEAN_WT,
    ST_ROOT_GO,
    ST_ROOT_WT,
    ST_RECIP_GO,
    ST_RECIP_WT,
    ST_N_RD,
    ST_N_MUL1,
    ST_N_RND1,
    ST_N_MUL2,
    ST_N_RND2,
    ST_N_WR,
    ST_F2_BIAS,
    ST_F2_INIT,
    ST_F2_RD,
    ST_F2_MUL,
    ST_F2_ACC,
    ST_F2_WR,
    ST_DONE
  } state_e;

  function automatic logic [31:0] round_sat(input logic [63:0] acc);
    logic signed [48:0] q;
    q = $signed({acc[63], acc[63:16]}) + $signed({48'd0, acc[15]});
    if (q > 49'sh0_0000_7FFF_FFFF) begin
      round_sat = 32'h7FFF_FFFF;
    end else if (q < -49'sh0_0000_8000_0000) begin
      round_sat = 32'h8000_0000;
    end else begin
      round_sat = q[31:0];
    end
  endfunction

  function automatic logic [63:0] bias_acc(input logic [31:0] b);
    bias_acc = {{16{b[31]}}, b, 16'd0};
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

// ----- design/feature_connector_mlp_rmsnorm.sv -----
// Feature connector: two-layer perceptron with an RMS norm between the layers, Q16.16.
// Load items (tuser 0..4) write weights, biases and gains; a read item (tuser 6)
// returns one output element, registered in the ST_RDOUT state. A frame element
// with tlast set starts the compute, during which the block takes no item. All products
// go through one shared 32x32 multiplier, each multiply-accumulate in a RAM read, a
// multiply and an accumulate step; the mean, root and reciprocal use a shared
// bit-serial divide/root unit. Output elements not yet computed read as zero.
module feature_connector_mlp_rmsnorm #(
  parameter int MAX_IN_DIM    = fcmr_pkg::FCMR_MAX_IN_DIM,
  parameter int MAX_MODEL_DIM = fcmr_pkg::FCMR_MAX_MODEL_DIM
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcmr_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // index [15:0], value [47:16]
  input  logic [fcmr_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  // operation [2:0]
  input  logic [fcmr_pkg::OP_W-1:0]       s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_index [7:0], out_value [39:8]
  output logic [fcmr_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  // kind [0]
  output logic [0:0]                      m_axis_tuser_o
);
  import fcmr_pkg::*;

  localparam int IW       = (MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM) : 1;
  localparam int MW       = (MAX_MODEL_DIM > 1) ? $clog2(MAX_MODEL_DIM) : 1;
  localparam int IDW      = $clog2(MAX_IN_DIM + 1);
  localparam int MDW      = $clog2(MAX_MODEL_DIM + 1);
  localparam int FW_DEPTH = MAX_IN_DIM * MAX_MODEL_DIM;
  localparam int SW_DEPTH = MAX_MODEL_DIM * MAX_MODEL_DIM;
  localparam int FWAW     = (FW_DEPTH > 1) ? $clog2(FW_DEPTH) : 1;
  localparam int SWAW     = (SW_DEPTH > 1) ? $clog2(SW_DEPTH) : 1;

  state_e state_q, state_d;

  logic [7:0] in_dim_q;
  logic [8:0] model_dim_q;
  logic       use_b1_q, use_gain_q, use_b2_q;

  logic [IW-1:0]   kin_q;
  logic [MW-1:0]   kmd_q, i_q, rd_addr_q;
  logic [FWAW-1:0] fwa_q;
  logic [SWAW-1:0] swa_q;
  logic [63:0]     acc_q, prod_q, ss_q, mean_q, root_q;
  logic [31:0]     hid_q, n_q, scale_q;
  logic [OUT_IDX_W-1:0] rd_idx_q;
  logic            rd_ok_q;
  logic [MAX_MODEL_DIM-1:0] ovalid_q;

  logic            m_valid_q, m_kind_q;
  logic [OUT_IDX_W-1:0] m_idx_q;
  logic [31:0]     m_val_q;

  logic        s_acc;
  logic [OP_W-1:0] s_op;
  logic [INDEX_W-1:0] s_idx;
  logic [31:0] s_idx_ext;
  logic [31:0] s_val;

  logic [IDW-1:0] din_eff;
  logic [MDW-1:0] dm_eff;
  logic           kin_last, kmd_last, i_last;

  logic signed [31:0] mul_a, mul_b;
  dsu_req_t dsu_req;
  dsu_rsp_t dsu_rsp;

  logic fw_we, fw_re, b1_we, b1_re, gn_we, gn_re, sw_we, sw_re, b2_we, b2_re;
  logic fr_we, fr_re, hd_we, hd_re, ov_we, ov_re;
  logic [MW-1:0] hd_raddr, hd_waddr;
  logic [31:0]   hd_wdata;
  logic [31:0] fw_rd, b1_rd, gn_rd, sw_rd, b2_rd, fr_rd, hd_rd, ov_rd;

  assign s_idx     = s_axis_tdata_i[INDEX_W-1:0];
  assign s_val     = s_axis_tdata_i[S_DATA_W-1:INDEX_W];
  assign s_op      = s_axis_tuser_i;
  assign s_idx_ext = 32'(s_idx);
  assign s_axis_tready_o = (state_q == ST_IDLE) && !m_valid_q;
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (in_dim_q == 8'd0) begin
      din_eff = IDW'(1);
    end else if (32'(in_dim_q) > 32'(MAX_IN_DIM)) begin
      din_eff = IDW'(MAX_IN_DIM);
    end else begin
      din_eff = IDW'(in_dim_q);
    end
    if (model_dim_q == 9'd0) begin
      dm_eff = MDW'(1);
    end else if (32'(model_dim_q) > 32'(MAX_MODEL_DIM)) begin
      dm_eff = MDW'(MAX_MODEL_DIM);
    end else begin
      dm_eff = MDW'(model_dim_q);
    end
    kin_last = (IDW'(kin_q) == din_eff - IDW'(1));
    kmd_last = (MDW'(kmd_q) == dm_eff - MDW'(1));
    i_last   = (MDW'(i_q) == dm_eff - MDW'(1));
  end

  fcmr_ram #(.W(32), .DEPTH(FW_DEPTH)) u_fw (
    .clk_i, .we_i(fw_we), .waddr_i(s_idx_ext[FWAW-1:0]), .wdata_i(s_val),
    .re_i(fw_re), .raddr_i(fwa_q), .rdata_o(fw_rd));
  fcmr_ram #(.W(32), .DEPTH(MAX_MODEL_DIM)) u_b1 (
    .clk_i, .we_i(b1_we), .waddr_i(s_idx_ext[MW-1:0]), .wdata_i(s_val),
    .re_i(b1_re), .raddr_i(i_q), .rdata_o(b1_rd));
  fcmr_ram #(.W(32), .DEPTH(MAX_MODEL_DIM)) u_gn (
    .clk_i, .we_i(gn_we), .waddr_i(s_idx_ext[MW-1:0]), .wdata_i(s_val),
    .re_i(gn_re), .raddr_i(i_q), .rdata_o(gn_rd));
  fcmr_ram #(.W(32), .DEPTH(SW_DEPTH)) u_sw (
    .clk_i, .we_i(sw_we), .waddr_i(s_idx_ext[SWAW-1:0]), .wdata_i(s_val),
    .re_i(sw_re), .raddr_i(swa_q), .rdata_o(sw_rd));
  fcmr_ram #(.W(32), .DEPTH(MAX_MODEL_DIM)) u_b2 (
    .clk_i, .we_i(b2_we), .waddr_i(s_idx_ext[MW-1:0]), .wdata_i(s_val),
    .re_i(b2_re), .raddr_i(i_q), .rdata_o(b2_rd));
  fcmr_ram #(.W(32), .DEPTH(MAX_IN_DIM)) u_fr (
    .clk_i, .we_i(fr_we), .waddr_i(s_idx_ext[IW-1:0]), .wdata_i(s_val),
    .re_i(fr_re), .raddr_i(kin_q), .rdata_o(fr_rd));
  fcmr_ram #(.W(32), .DEPTH(MAX_MODEL_DIM)) u_hd (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .re_i(hd_re), .raddr_i(hd_raddr), .rdata_o(hd_rd));
  fcmr_ram #(.W(32), .DEPTH(MAX_MODEL_DIM)) u_ov (
    .clk_i, .we_i(ov_we), .waddr_i(i_q), .wdata_i(round_sat(acc_q)),
    .re_i(ov_re), .raddr_i(s_idx_ext[MW-1:0]), .rdata_o(ov_rd));

  fcmr_dsu u_dsu (
    .clk_i, .rst_ni, .req_i(dsu_req), .rsp_o(dsu_rsp));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && s_op == OP_FRAME && s_axis_tlast_i) begin
          state_d = ST_F1_BIAS;
        end else if (s_acc && s_op == OP_RD_OUT) begin
          state_d = ST_RDOUT;
        end
      end
      ST_RDOUT:    state_d = ST_IDLE;
      ST_F1_BIAS:  state_d = ST_F1_INIT;
      ST_F1_INIT:  state_d = ST_F1_RD;
      ST_F1_RD:    state_d = ST_F1_MUL;
      ST_F1_MUL:   state_d = ST_F1_ACC;
      ST_F1_ACC:   state_d = kin_last ? ST_F1_HID : ST_F1_RD;
      ST_F1_HID:   state_d = ST_F1_SQM;
      ST_F1_SQM:   state_d = ST_F1_SQA;
      ST_F1_SQA:   state_d = i_last ? ST_MEAN_GO : ST_F1_BIAS;
      ST_MEAN_GO:  state_d = ST_MEAN_WT;
      ST_MEAN_WT:  state_d = dsu_rsp.done ? ST_ROOT_GO : ST_MEAN_WT;
      ST_ROOT_GO:  state_d = ST_ROOT_WT;
      ST_ROOT_WT:  state_d = dsu_rsp.done ? ST_RECIP_GO : ST_ROOT_WT;
      ST_RECIP_GO: state_d = ST_RECIP_WT;
      ST_RECIP_WT: state_d = dsu_rsp.done ? ST_N_RD : ST_RECIP_WT;
      ST_N_RD:     state_d = ST_N_MUL1;
      ST_N_MUL1:   state_d = ST_N_RND1;
      ST_N_RND1:   state_d = use_gain_q ? ST_N_MUL2 : ST_N_WR;
      ST_N_MUL2:   state_d = ST_N_RND2;
      ST_N_RND2:   state_d = ST_N_WR;
      ST_N_WR:     state_d = i_last ? ST_F2_BIAS : ST_N_RD;
      ST_F2_BIAS:  state_d = ST_F2_INIT;
      ST_F2_INIT:  state_d = ST_F2_RD;
      ST_F2_RD:    state_d = ST_F2_MUL;
      ST_F2_MUL:   state_d = ST_F2_ACC;
      ST_F2_ACC:   state_d = kmd_last ? ST_F2_WR : ST_F2_RD;
      ST_F2_WR:    state_d = i_last ? ST_DONE : ST_F2_BIAS;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fw_we = 1'b0; b1_we = 1'b0; gn_we = 1'b0; sw_we = 1'b0; b2_we = 1'b0;
    fr_we = 1'b0; ov_re = 1'b0;
    fw_re = 1'b0; b1_re = 1'b0; gn_re = 1'b0; sw_re = 1'b0; b2_re = 1'b0;
    fr_re = 1'b0; hd_re = 1'b0; hd_we = 1'b0; ov_we = 1'b0;
    hd_raddr = i_q;
    hd_waddr = i_q;
    hd_wdata = n_q;
    mul_a = $signed(fr_rd);
    mul_b = $signed(fw_rd);
    dsu_req.start = 1'b0;
    dsu_req.op    = DSU_DIV;
    dsu_req.a     = ss_q;
    dsu_req.b     = 64'(dm_eff);
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          fw_we = (s_op == OP_FC1_W) && (s_idx_ext < 32'(FW_DEPTH));
          b1_we = (s_op == OP_FC1_B) && (s_idx_ext < 32'(MAX_MODEL_DIM));
          gn_we = (s_op == OP_GAIN) && (s_idx_ext < 32'(MAX_MODEL_DIM));
          sw_we = (s_op == OP_FC2_W) && (s_idx_ext < 32'(SW_DEPTH));
          b2_we = (s_op == OP_FC2_B) && (s_idx_ext < 32'(MAX_MODEL_DIM));
          fr_we = (s_op == OP_FRAME) && (s_idx_ext < 32'(MAX_IN_DIM));
          ov_re = (s_op == OP_RD_OUT) && (s_idx_ext < 32'(MAX_MODEL_DIM));
        end
      end
      ST_F1_BIAS: b1_re = 1'b1;
      ST_F1_RD: begin
        fr_re = 1'b1;
        fw_re = 1'b1;
      end
      ST_F1_HID: begin
        hd_we    = 1'b1;
        hd_wdata = round_sat(acc_q);
      end
      ST_F1_SQM: begin
        mul_a = $signed(hid_q);
        mul_b = $signed(hid_q);
      end
      ST_MEAN_GO: dsu_req.start = 1'b1;
      ST_ROOT_GO: begin
        dsu_req.start = 1'b1;
        dsu_req.op    = DSU_SQRT;
        dsu_req.a     = mean_q;
      end
      ST_RECIP_GO: begin
        dsu_req.start = 1'b1;
        dsu_req.a     = ONE_Q32;
        dsu_req.b     = root_q;
      end
      ST_N_RD: begin
        hd_re = 1'b1;
        gn_re = 1'b1;
      end
      ST_N_MUL1: begin
        mul_a = $signed(hd_rd);
        mul_b = $signed(scale_q);
      end
      ST_N_MUL2: begin
        mul_a = $signed(n_q);
        mul_b = $signed(gn_rd);
      end
      ST_N_WR: hd_we = 1'b1;
      ST_F2_BIAS: b2_re = 1'b1;
      ST_F2_RD: begin
        hd_re    = 1'b1;
        hd_raddr = kmd_q;
        sw_re    = 1'b1;
      end
      ST_F2_MUL: begin
        mul_a = $signed(hd_rd);
        mul_b = $signed(sw_rd);
      end
      ST_F2_WR: ov_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_dim_q    <= 8'd64;
      model_dim_q <= 9'd256;
      use_b1_q    <= 1'b1;
      use_gain_q  <= 1'b1;
      use_b2_q    <= 1'b1;
      ovalid_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IN_DIM:    in_dim_q    <= cfg_data_i[7:0];
          CFG_MODEL_DIM: model_dim_q <= cfg_data_i;
          CFG_USE_B1:    use_b1_q    <= cfg_data_i[0];
          CFG_USE_GAIN:  use_gain_q  <= cfg_data_i[0];
          CFG_USE_B2:    use_b2_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (ov_we) begin
        ovalid_q[i_q] <= 1'b1;
      end
      if (state_q == ST_RDOUT || state_q == ST_DONE) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a * mul_b);
    case (state_q)
      ST_IDLE: begin
        i_q   <= '0;
        fwa_q <= '0;
        swa_q <= '0;
        ss_q  <= '0;
        if (s_acc) begin
          rd_idx_q  <= s_idx[OUT_IDX_W-1:0];
          rd_ok_q   <= (s_idx_ext < 32'(MAX_MODEL_DIM));
          rd_addr_q <= s_idx_ext[MW-1:0];
        end
      end
      ST_RDOUT: begin
        m_kind_q <= KIND_READ;
        m_idx_q  <= rd_idx_q;
        m_val_q  <= (rd_ok_q && ovalid_q[rd_addr_q]) ? ov_rd : 32'd0;
      end
      ST_F1_INIT: begin
        acc_q <= use_b1_q ? bias_acc(b1_rd) : 64'd0;
        kin_q <= '0;
      end
      ST_F1_ACC: begin
        acc_q <= acc_q + prod_q;
        kin_q <= kin_q + IW'(1);
        fwa_q <= fwa_q + FWAW'(1);
      end
      ST_F1_HID: hid_q <= round_sat(acc_q);
      ST_F1_SQA: begin
        ss_q <= sat_add(ss_q, prod_q);
        i_q  <= i_last ? '0 : i_q + MW'(1);
      end
      ST_MEAN_WT: begin
        if (dsu_rsp.done) begin
          mean_q <= sat_add(dsu_rsp.result, EPS_Q32);
        end
      end
      ST_ROOT_WT: begin
        if (dsu_rsp.done) begin
          root_q <= dsu_rsp.result;
        end
      end
      ST_RECIP_WT: begin
        if (dsu_rsp.done) begin
          scale_q <= dsu_rsp.result[31:0];
        end
      end
      ST_N_RND1, ST_N_RND2: n_q <= round_sat(prod_q);
      ST_N_WR: i_q <= i_last ? '0 : i_q + MW'(1);
      ST_F2_INIT: begin
        acc_q <= use_b2_q ? bias_acc(b2_rd) : 64'd0;
        kmd_q <= '0;
      end
      ST_F2_ACC: begin
        acc_q <= acc_q + prod_q;
        kmd_q <= kmd_q + MW'(1);
        swa_q <= swa_q + SWAW'(1);
      end
      ST_F2_WR: i_q <= i_last ? '0 : i_q + MW'(1);
      ST_DONE: begin
        m_kind_q <= KIND_DONE;
        m_idx_q  <= '0;
        m_val_q  <= '0;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_val_q, m_idx_q};
  assign m_axis_tuser_o  = m_kind_q;

endmodule

// ----- design/fcmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fcmr_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fcmr_dsu.sv -----
// Iterative 64-bit divide and square-root unit, one quotient or root bit per cycle.
module fcmr_dsu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcmr_pkg::dsu_req_t req_i,
  output fcmr_pkg::dsu_rsp_t rsp_o
);
  import fcmr_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  dsu_op_e     op_q;
  logic [63:0] x_q, d_q, rem_q, res_q, bit_q;

  logic [64:0] rem_sh;
  logic        div_ge, sq_ge;
  logic [63:0] sq_t;

  always_comb begin
    rem_sh = {rem_q, x_q[63]};
    div_ge = (rem_sh >= {1'b0, d_q});
    sq_t   = res_q + bit_q;
    sq_ge  = (x_q >= sq_t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == DSU_DIV) ? 6'd63 : 6'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      x_q   <= req_i.a;
      d_q   <= req_i.b;
      rem_q <= '0;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (op_q == DSU_DIV) begin
        rem_q <= div_ge ? 64'(rem_sh - {1'b0, d_q}) : rem_sh[63:0];
        x_q   <= {x_q[62:0], div_ge};
      end else begin
        if (sq_ge) begin
          x_q   <= x_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == DSU_DIV) ? x_q : res_q;

endmodule

// ----- tb/sv/feature_connector_mlp_rmsnorm_tb.sv -----
// Testbench for the feature connector MLP with RMS norm: streams requests, predicts results.
`timescale 1ns / 1ps

class fc_scoreboard;
  typedef struct {
    bit        kind;
    bit [7:0]  idx;
    bit [31:0] val;
  } result_t;

  int fc1_w[32768];
  int fc1_b[256];
  int gain[256];
  int fc2_w[65536];
  int fc2_b[256];
  int fbuf[128];
  int hid[256];
  int outv[256];
  int din_raw;
  int dm_raw;
  bit use_b1;
  bit use_gain;
  bit use_b2;
  result_t expq[$];
  int errors;

  function new();
    foreach (outv[i]) outv[i] = 0;
    din_raw = 64;
    dm_raw = 256;
    use_b1 = 1;
    use_gain = 1;
    use_b2 = 1;
    errors = 0;
  endfunction

  function int din_c();
    return din_raw < 1 ? 1 : (din_raw > 128 ? 128 : din_raw);
  endfunction

  function int dm_c();
    return dm_raw < 1 ? 1 : (dm_raw > 256 ? 256 : dm_raw);
  endfunction

  function void set_cfg(logic [2:0] idx, int val);
    case (idx)
      fcmr_pkg::CFG_IN_DIM:    din_raw = val & 8'hFF;
      fcmr_pkg::CFG_MODEL_DIM: dm_raw = val & 9'h1FF;
      fcmr_pkg::CFG_USE_B1:    use_b1 = val[0];
      fcmr_pkg::CFG_USE_GAIN:  use_gain = val[0];
      fcmr_pkg::CFG_USE_B2:    use_b2 = val[0];
      default: ;
    endcase
  endfunction

  function int rnd(longint acc);
    longint q;
    q = (acc >>> 16) + longint'(acc[15]);
    if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return int'(q);
  endfunction

  function void compute();
    int din;
    int dm;
    longint acc;
    bit [63:0] ss;
    bit [64:0] t;
    bit [63:0] mean;
    bit [63:0] rt;
    bit [63:0] cand;
    bit [63:0] scale;
    int n;
    din = din_c();
    dm = dm_c();
    for (int i = 0; i < dm; i++) begin
      acc = use_b1 ? longint'(fc1_b[i]) <<< 16 : 0;
      for (int k = 0; k < din; k++) acc += longint'(fbuf[k]) * longint'(fc1_w[i*din+k]);
      hid[i] = rnd(acc);
    end
    ss = 0;
    for (int i = 0; i < dm; i++) begin
      t = {1'b0, ss} + {1'b0, 64'(longint'(hid[i]) * longint'(hid[i]))};
      ss = t[64] ? '1 : t[63:0];
    end
    mean = ss / 64'(dm);
    t = {1'b0, mean} + 65'd4295;
    mean = t[64] ? '1 : t[63:0];
    rt = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = rt | (64'd1 << b);
      if (cand * cand <= mean) rt = cand;
    end
    scale = 64'h1_0000_0000 / rt;
    for (int i = 0; i < dm; i++) begin
      n = rnd(longint'(hid[i]) * longint'(int'(scale[31:0])));
      if (use_gain) n = rnd(longint'(n) * longint'(gain[i]));
      hid[i] = n;
    end
    for (int i = 0; i < dm; i++) begin
      acc = use_b2 ? longint'(fc2_b[i]) <<< 16 : 0;
      for (int k = 0; k < dm; k++) acc += longint'(hid[k]) * longint'(fc2_w[i*dm+k]);
      outv[i] = rnd(acc);
    end
  endfunction

  function void note_request(logic [2:0] op, logic [15:0] idx, logic [31:0] val, logic last);
    result_t r;
    case (op)
      fcmr_pkg::OP_FC1_W: if (idx < 32768) fc1_w[idx] = val;
      fcmr_pkg::OP_FC1_B: if (idx < 256) fc1_b[idx] = val;
      fcmr_pkg::OP_GAIN:  if (idx < 256) gain[idx] = val;
      fcmr_pkg::OP_FC2_W: fc2_w[idx] = val;
      fcmr_pkg::OP_FC2_B: if (idx < 256) fc2_b[idx] = val;
      fcmr_pkg::OP_FRAME: begin
        if (idx < 128) fbuf[idx] = val;
        if (last) begin
          compute();
          r.kind = fcmr_pkg::KIND_DONE;
          r.idx = 0;
          r.val = 0;
          expq.push_back(r);
        end
      end
      fcmr_pkg::OP_RD_OUT: begin
        r.kind = fcmr_pkg::KIND_READ;
        r.idx = idx[7:0];
        r.val = idx < 256 ? outv[idx] : 0;
        expq.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [39:0] data, logic kind);
    result_t r;
    if (expq.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result kind %0d data %h", kind, data);
      return;
    end
    r = expq.pop_front();
    if (kind !== r.kind || data[7:0] !== r.idx || data[39:8] !== r.val) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp kind %0d idx %0d val %h, got kind %0d idx %0d val %h",
                 r.kind, r.idx, r.val, kind, data[7:0], data[39:8]);
    end
  endfunction
endclass

module feature_connector_mlp_rmsnorm_tb;
  import fcmr_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 s_valid;
  logic                 s_ready;
  logic [S_DATA_W-1:0]  s_data;
  logic [OP_W-1:0]      s_user;
  logic                 s_last;
  logic                 m_valid;
  logic                 m_ready;
  logic [M_DATA_W-1:0]  m_data;
  logic [0:0]           m_user;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_cycles = 0;
  bit frame_ready = 0;
  fc_scoreboard sb = new();

  feature_connector_mlp_rmsnorm dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_ready = 1'b0;
        hold_cycles--;
      end else begin
        m_ready = ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data, m_user[0]);
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      5: return 32'h0001_0000 + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic send_req(logic [2:0] op, logic [15:0] idx, logic [31:0] val, logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) @(negedge clk_i);
    s_valid = 1'b1;
    s_user = op;
    s_data = {val, idx};
    s_last = last;
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(op, idx, val, last);
    @(negedge clk_i);
    s_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, int val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = CFG_DAT_W'(val);
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.set_cfg(idx, val);
  endtask

  task automatic set_dims(int din, int dm, bit b1, bit g, bit b2);
    drain();
    write_cfg(CFG_IN_DIM, din);
    write_cfg(CFG_MODEL_DIM, dm);
    write_cfg(CFG_USE_B1, b1);
    write_cfg(CFG_USE_GAIN, g);
    write_cfg(CFG_USE_B2, b2);
    frame_ready = 0;
  endtask

  task automatic preload();
    int din;
    int dm;
    din = sb.din_c();
    dm = sb.dm_c();
    for (int i = 0; i < din * dm; i++) send_req(OP_FC1_W, 16'(i), rand_val(), 1'b0);
    for (int i = 0; i < dm; i++) begin
      send_req(OP_FC1_B, 16'(i), rand_val(), 1'b0);
      send_req(OP_GAIN, 16'(i), rand_val(), 1'b0);
      send_req(OP_FC2_B, 16'(i), rand_val(), 1'b0);
    end
    for (int i = 0; i < dm * dm; i++) send_req(OP_FC2_W, 16'(i), rand_val(), 1'b0);
    for (int i = 0; i < din; i++) send_req(OP_FRAME, 16'(i), rand_val(), 1'b0);
    frame_ready = 1;
  endtask

  task automatic rand_item();
    int pick;
    logic [15:0] idx;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    idx = 16'($urandom);
    if (pick < 8) begin
      op = $urandom_range(0, 1) ? 3'd7 : 3'($urandom_range(0, 4));
      if (op == OP_FC1_W) idx[15] = 1'b1;
      else if (op != 3'd7 && op != OP_FC2_W) idx[15:8] = idx[15:8] | 8'h01;
      send_req(op, idx, rand_val(), 1'($urandom_range(0, 1)));
    end else if (pick < 35) begin
      op = 3'($urandom_range(0, 4));
      if (op == OP_FC1_W) idx[15] = 1'b0;
      else if (op != OP_FC2_W) idx = 16'($urandom_range(0, sb.dm_c() - 1));
      send_req(op, idx, rand_val(), 1'b0);
    end else if (pick < 75) begin
      if ($urandom_range(0, 9) != 0) idx = 16'($urandom_range(0, sb.din_c() - 1));
      send_req(OP_FRAME, idx, rand_val(), frame_ready && $urandom_range(0, 99) < 15);
    end else begin
      if ($urandom_range(0, 3) != 0) idx = 16'($urandom_range(0, sb.dm_c() - 1));
      send_req(OP_RD_OUT, idx, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random(int n);
    repeat (n) rand_item();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = '0;
    s_last = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_req(OP_RD_OUT, 16'd0, 32'd0, 1'b0);
    send_req(OP_RD_OUT, 16'd255, 32'd0, 1'b0);
    send_req(OP_RD_OUT, 16'd256, 32'd0, 1'b1);
    send_req(OP_RD_OUT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_req(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_req(OP_FC1_W, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    send_req(OP_FC1_B, 16'd256, 32'h8000_0000, 1'b0);
    send_req(OP_GAIN, 16'hFFFF, 32'd1, 1'b0);
    send_req(OP_FC2_B, 16'd256, 32'd1, 1'b1);

    // all-zero hidden vector: epsilon alone sets the scale
    set_dims(0, 2, 0, 0, 1);
    send_req(OP_FC1_W, 16'd0, 32'd0, 1'b0);
    send_req(OP_FC1_W, 16'd1, 32'd0, 1'b0);
    send_req(OP_FC2_B, 16'd0, 32'h7FFF_FFFF, 1'b0);
    send_req(OP_FC2_B, 16'd1, 32'h8000_0000, 1'b0);
    for (int i = 0; i < 4; i++) send_req(OP_FC2_W, 16'(i), 32'h0001_0000, 1'b0);
    send_req(OP_FRAME, 16'd0, 32'h7FFF_FFFF, 1'b1);
    send_req(OP_RD_OUT, 16'd0, 32'd0, 1'b0);
    send_req(OP_RD_OUT, 16'd1, 32'd0, 1'b0);

    set_dims(0, 2, 1, 1, 1);
    preload();
    send_req(OP_FRAME, 16'd200, 32'd5, 1'b1);
    send_req(OP_FRAME, 16'd0, 32'h8000_0000, 1'b1);
    send_req(OP_RD_OUT, 16'd0, 32'd0, 1'b0);
    send_req(OP_RD_OUT, 16'd1, 32'd0, 1'b0);

    set_dims(4, 4, 1, 1, 1);
    preload();
    run_random(20);
    hold_cycles = 400;
    repeat (30) send_req(OP_RD_OUT, 16'($urandom_range(0, 3)), 32'd0, 1'b0);
    drain();
    run_random(10);

    snd_idle_pct = 60;
    set_dims(3, 5, 0, 1, 0);
    preload();
    run_random(25);

    snd_idle_pct = 0;
    rcv_stall_pct = 60;
    set_dims(255, 0, 1, 0, 1);
    preload();
    run_random(15);

    snd_idle_pct = 31;
    rcv_stall_pct = 31;
    set_dims(1, 6, 1, 1, 1);
    preload();
    run_random(15);

    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    set_dims(128, 511, 1, 1, 1);
    run_random(10);

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- feature_connector_mlp_rmsnorm.f -----
design/fcmr_pkg.sv
design/fcmr_ram.sv
design/fcmr_dsu.sv
design/feature_connector_mlp_rmsnorm.sv
tb/sv/feature_connector_mlp_rmsnorm_tb.sv
